// File: src/assert_macros.svh
// Assertion macros used by the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: src/lfap_pkg.sv
// Package: widths, codes and fixed-point helpers of the line flow proximal step.
package lfap_pkg;

    localparam int FRAC_BITS = 16;
    localparam int Q_W       = 32;
    localparam int SAT_W     = 72;
    localparam int MUL_W     = 34;
    localparam int NUM_W     = 36;
    localparam int DEN_W     = 34;
    localparam int DIV_STEPS = 32;
    localparam int DIV_LAT   = DIV_STEPS + 2;
    localparam int ADDR_W    = 4;

    localparam logic [DEN_W-1:0] Q_ONE = DEN_W'(1) << FRAC_BITS;

    localparam logic [1:0] REG_REACTANCE  = 2'd0;
    localparam logic [1:0] REG_FLOW_LIMIT = 2'd1;
    localparam logic [1:0] REG_SLACK_END  = 2'd2;

    localparam logic [1:0] SLACK_NONE  = 2'd0;
    localparam logic [1:0] SLACK_END_A = 2'd1;
    localparam logic [1:0] SLACK_END_B = 2'd2;

    typedef enum logic [1:0] {
        LIMIT_INTERIOR = 2'd0,
        LIMIT_UPPER    = 2'd1,
        LIMIT_LOWER    = 2'd2
    } limit_case_t;

    typedef struct packed {
        logic             neg;
        logic             ovf;
        logic [DEN_W-1:0] rem;
        logic [31:0]      work;
        logic [DEN_W-1:0] den;
    } div_stage_t;

    // Clamp a wide signed value to the 32-bit signed range.
    function automatic logic signed [Q_W-1:0] sat_q(input logic signed [SAT_W-1:0] v);
        logic [SAT_W-Q_W:0] top;
        top = v[SAT_W-1:Q_W-1];
        if ((top == '0) || (top == '1))
            return v[Q_W-1:0];
        else if (v[SAT_W-1])
            return {1'b1, {(Q_W-1){1'b0}}};
        else
            return {1'b0, {(Q_W-1){1'b1}}};
    endfunction

    function automatic logic signed [SAT_W-1:0] ext(input logic signed [Q_W-1:0] v);
        return {{(SAT_W-Q_W){v[Q_W-1]}}, v};
    endfunction

    function automatic logic signed [MUL_W-1:0] ext_m(input logic signed [Q_W-1:0] v);
        return {{(MUL_W-Q_W){v[Q_W-1]}}, v};
    endfunction

    function automatic logic signed [NUM_W-1:0] ext_n(input logic signed [Q_W-1:0] v);
        return {{(NUM_W-Q_W){v[Q_W-1]}}, v};
    endfunction

    // Fixed-point product, floored, then saturated.
    function automatic logic signed [Q_W-1:0] mul_q(input logic signed [MUL_W-1:0] a,
                                                   input logic signed [MUL_W-1:0] b);
        logic signed [2*MUL_W-1:0] p;
        logic signed [2*MUL_W-1:0] sh;
        p  = a * b;
        sh = p >>> FRAC_BITS;
        return sat_q({{(SAT_W-2*MUL_W){sh[2*MUL_W-1]}}, sh});
    endfunction

endpackage

// File: src/line_flow_admm_proximal_step.sv
// Top level: pipelined closed-form ADMM proximal update for one transmission line.
//
//  channel | direction | handshake               | payload
//  s_      | in        | s_tvalid / s_tready     | s_tdata 384 bits, twelve iterate values
//  m_      | out       | m_tvalid / m_tready     | m_tdata 128 bits, m_tuser limit case
//  apb     | in        | psel, penable, pready   | paddr, pwdata, prdata
//
// One line enters per cycle while the output is not stalled; each line passes two
// rounds of 34-stage dividers (angle solve, then end powers).
// Reset clears the valid bits and config registers only.
// A result stalled at the output freezes every stage; nothing moves, nothing drops.
module line_flow_admm_proximal_step (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    // fields low to high: power_prev_a, power_netavg_a, price_prev_a, dual_avg_a,
    // angle_avg_a, dual_prev_a, power_prev_b, power_netavg_b, price_prev_b,
    // dual_avg_b, angle_avg_b, dual_prev_b
    input  logic [383:0]                s_tdata,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    // fields low to high: angle_out_a, angle_out_b, power_out_a, power_out_b
    output logic [127:0]                m_tdata,
    // fields low to high: limit_case
    output logic [1:0]                  m_tuser,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [lfap_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);
    import lfap_pkg::*;

    typedef struct packed {
        logic signed [Q_W-1:0] a;
        logic signed [Q_W-1:0] b;
        logic signed [Q_W-1:0] c;
        logic signed [Q_W-1:0] d;
    } side1_t;

    typedef struct packed {
        logic signed [Q_W-1:0] t1;
        logic signed [Q_W-1:0] t2;
        limit_case_t           kind;
    } side2_t;

    logic en;

    // configuration
    logic [30:0] reactance_reg;
    logic [30:0] flow_limit_reg;
    logic [1:0]  slack_end_reg;
    logic signed [Q_W-1:0]   r2_reg;
    logic signed [Q_W-1:0]   lim_reg;
    logic signed [MUL_W-1:0] two_r2_reg;
    logic [DEN_W-1:0]        four_r2_reg;
    logic signed [MUL_W-1:0] r_m;
    logic mode_a;
    logic mode_b;
    logic cfg_wr;

    // stage registers
    logic [9:0] v_reg;
    logic signed [Q_W-1:0] x_reg [12];
    logic signed [Q_W-1:0] pa1_reg, b1_reg, pc1_reg, d1_reg;
    side1_t s2_reg;
    side1_t s3_reg;
    logic signed [Q_W-1:0] mr2d3_reg, mr2b3_reg, m2b3_reg;
    side1_t side1_reg [DIV_LAT];
    side1_t s5_reg;
    logic signed [Q_W-1:0] t1_5_reg, diff5_reg;
    logic signed [Q_W-1:0] t1_6_reg, diff6_reg;
    logic                  feas6_reg, feas7_reg, feas8_reg, feas9_reg;
    logic signed [Q_W-1:0] t1_7_reg, t1_8_reg, t1_9_reg;
    logic signed [Q_W-1:0] diff7_reg, diff8_reg, diff9_reg;
    logic signed [Q_W-1:0] e1_reg [3];
    logic signed [Q_W-1:0] e2_reg [3];
    logic signed [Q_W-1:0] e4_reg [3];
    logic signed [Q_W-1:0] e3_reg;
    logic signed [Q_W-1:0] sq1_reg [3];
    logic signed [Q_W-1:0] sq2_reg [3];
    logic signed [Q_W-1:0] sq4_reg [3];
    logic signed [Q_W-1:0] sq3_reg;
    logic signed [Q_W-1:0] sq1b_reg [3];
    logic signed [Q_W-1:0] sq2b_reg [3];
    logic signed [Q_W-1:0] w4_reg [3];
    logic signed [Q_W-1:0] w3_reg;
    logic signed [MUL_W-1:0] obj_reg [3];
    side2_t s10_reg;
    side2_t side2_reg [DIV_LAT];
    logic                  out_valid_reg;
    logic signed [Q_W-1:0] out_t1_reg, out_t2_reg, out_pa_reg, out_pb_reg;
    limit_case_t           out_kind_reg;

    // combinational
    logic signed [NUM_W-1:0] num_t1_next, num_d_next;
    logic [DEN_W-1:0]        den_a_next;
    logic                    div1_valid, div_d_valid, div2a_valid, div2b_valid;
    logic signed [Q_W-1:0]   q_t1, q_d, q_pa, q_pb;
    logic signed [Q_W-1:0]   xs [3];
    logic signed [Q_W-1:0]   diff5_next;
    logic signed [Q_W-1:0]   chosen;
    side2_t                  s10_next;
    logic signed [NUM_W-1:0] num_pa_next, num_pb_next;

    assign en       = !out_valid_reg || m_tready;
    assign s_tready = en;
    assign pready   = 1'b1;
    assign cfg_wr   = psel && penable && pwrite && pready;
    assign mode_a   = (slack_end_reg == SLACK_END_A);
    assign mode_b   = (slack_end_reg == SLACK_END_B);
    assign r_m      = {{(MUL_W-31){1'b0}}, reactance_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reactance_reg  <= 31'(Q_ONE);
            flow_limit_reg <= 31'(Q_ONE);
            slack_end_reg  <= SLACK_NONE;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[3:2])
                REG_REACTANCE:  reactance_reg  <= pwdata[30:0];
                REG_FLOW_LIMIT: flow_limit_reg <= pwdata[30:0];
                REG_SLACK_END:  slack_end_reg  <= pwdata[1:0];
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_REACTANCE:  prdata = {1'b0, reactance_reg};
            REG_FLOW_LIMIT: prdata = {1'b0, flow_limit_reg};
            REG_SLACK_END:  prdata = {30'd0, slack_end_reg};
            default:        prdata = '0;
        endcase
    end

    // Config-derived terms; r2_reg and lim_reg are registered from the config, the others from r2_reg.
    always_ff @(posedge clk)
    begin
        r2_reg      <= mul_q(r_m, r_m);
        lim_reg     <= mul_q(r_m, {{(MUL_W-31){1'b0}}, flow_limit_reg});
        two_r2_reg  <= MUL_W'(2 * Q_ONE) + ext_m(r2_reg);
        four_r2_reg <= DEN_W'(4 * Q_ONE) + DEN_W'(r2_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            v_reg[0]      <= s_tvalid;
            v_reg[1]      <= v_reg[0];
            v_reg[2]      <= v_reg[1];
            v_reg[3]      <= v_reg[2];
            v_reg[4]      <= div1_valid && div_d_valid;
            v_reg[5]      <= v_reg[4];
            v_reg[6]      <= v_reg[5];
            v_reg[7]      <= v_reg[6];
            v_reg[8]      <= v_reg[7];
            v_reg[9]      <= v_reg[8];
            out_valid_reg <= div2a_valid && div2b_valid;
        end
    end

    // Numerators and denominator of the angle solve by slack mode.
    always_comb
    begin
        den_a_next = four_r2_reg;
        priority if (mode_a)
        begin
            den_a_next  = DEN_W'(two_r2_reg);
            num_t1_next = '0;
            num_d_next  = ext_n(mr2d3_reg) + ext_n(s3_reg.a) - ext_n(s3_reg.c);
        end
        else if (mode_b)
        begin
            den_a_next  = DEN_W'(two_r2_reg);
            num_t1_next = ext_n(mr2b3_reg) - ext_n(s3_reg.a) + ext_n(s3_reg.c);
            num_d_next  = '0;
        end
        else
        begin
            num_t1_next = ext_n(m2b3_reg) - ext_n(s3_reg.a) + ext_n(s3_reg.c)
                        + (ext_n(s3_reg.d) <<< 1);
            num_d_next  = (ext_n(s3_reg.a) <<< 1) - ext_n(mr2b3_reg)
                        - (ext_n(s3_reg.c) <<< 1) + ext_n(mr2d3_reg);
        end
    end

    lfap_div u_div_t1 (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (v_reg[3]),
        .num       (num_t1_next),
        .den       (den_a_next),
        .out_valid (div1_valid),
        .quo       (q_t1)
    );

    lfap_div u_div_d (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (v_reg[3]),
        .num       (num_d_next),
        .den       (den_a_next),
        .out_valid (div_d_valid),
        .quo       (q_d)
    );

    assign diff5_next = mode_b ? sat_q(-ext(q_t1)) : q_d;

    always_comb
    begin
        xs[0] = lim_reg;
        xs[1] = -lim_reg;
        xs[2] = diff5_reg;
    end

    function automatic logic signed [Q_W-1:0] pick(input limit_case_t k,
                                                  input logic signed [Q_W-1:0] lim,
                                                  input logic signed [Q_W-1:0] dif);
        unique case (k)
            LIMIT_UPPER:    return lim;
            LIMIT_LOWER:    return -lim;
            default:        return dif;
        endcase
    endfunction

    // Pick the limit case; upper wins ties, then lower.
    always_comb
    begin
        if (feas9_reg)
        begin
            priority if ((obj_reg[0] <= obj_reg[1]) && (obj_reg[0] <= obj_reg[2]))
                s10_next.kind = LIMIT_UPPER;
            else if (obj_reg[1] <= obj_reg[2])
                s10_next.kind = LIMIT_LOWER;
            else
                s10_next.kind = LIMIT_INTERIOR;
        end
        else
        begin
            s10_next.kind = (obj_reg[0] <= obj_reg[1]) ? LIMIT_UPPER : LIMIT_LOWER;
        end
        chosen = pick(s10_next.kind, lim_reg, diff9_reg);
        if (mode_b)
        begin
            s10_next.t2 = '0;
            s10_next.t1 = sat_q(-ext(chosen));
        end
        else
        begin
            s10_next.t1 = t1_9_reg;
            s10_next.t2 = sat_q(ext(t1_9_reg) + ext(chosen));
        end
    end

    assign num_pa_next = ext_n(s10_reg.t2) - ext_n(s10_reg.t1);
    assign num_pb_next = ext_n(s10_reg.t1) - ext_n(s10_reg.t2);

    lfap_div u_div_pa (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (v_reg[9]),
        .num       (num_pa_next),
        .den       ({{(DEN_W-31){1'b0}}, reactance_reg}),
        .out_valid (div2a_valid),
        .quo       (q_pa)
    );

    lfap_div u_div_pb (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (v_reg[9]),
        .num       (num_pb_next),
        .den       ({{(DEN_W-31){1'b0}}, reactance_reg}),
        .out_valid (div2b_valid),
        .quo       (q_pb)
    );

    // Datapath registers advance together on en.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 12; k++)
                x_reg[k] <= s_tdata[32*k +: 32];

            pa1_reg <= sat_q(ext(x_reg[0]) - ext(x_reg[1]) - ext(x_reg[2]));
            b1_reg  <= sat_q(ext(x_reg[3]) + ext(x_reg[4]) - ext(x_reg[5]));
            pc1_reg <= sat_q(ext(x_reg[6]) - ext(x_reg[7]) - ext(x_reg[8]));
            d1_reg  <= sat_q(ext(x_reg[9]) + ext(x_reg[10]) - ext(x_reg[11]));

            s2_reg.a <= mul_q(r_m, ext_m(pa1_reg));
            s2_reg.b <= b1_reg;
            s2_reg.c <= mul_q(r_m, ext_m(pc1_reg));
            s2_reg.d <= d1_reg;

            s3_reg    <= s2_reg;
            mr2d3_reg <= mul_q(ext_m(r2_reg), ext_m(s2_reg.d));
            mr2b3_reg <= mul_q(ext_m(r2_reg), ext_m(s2_reg.b));
            m2b3_reg  <= mul_q(two_r2_reg, ext_m(s2_reg.b));

            side1_reg[0] <= s3_reg;
            for (int k = 1; k < DIV_LAT; k++)
                side1_reg[k] <= side1_reg[k-1];

            s5_reg    <= side1_reg[DIV_LAT-1];
            t1_5_reg  <= q_t1;
            diff5_reg <= diff5_next;

            e3_reg <= sat_q(ext(t1_5_reg) - ext(s5_reg.b));
            for (int i = 0; i < 3; i++)
            begin
                e1_reg[i] <= sat_q(ext(xs[i]) - ext(s5_reg.a));
                e2_reg[i] <= sat_q(ext(xs[i]) + ext(s5_reg.c));
                e4_reg[i] <= sat_q(ext(t1_5_reg) + ext(xs[i]) - ext(s5_reg.d));
            end
            t1_6_reg  <= t1_5_reg;
            diff6_reg <= diff5_reg;
            feas6_reg <= (diff5_reg <= lim_reg) && (diff5_reg >= -lim_reg);

            sq3_reg <= mul_q(ext_m(e3_reg), ext_m(e3_reg));
            for (int i = 0; i < 3; i++)
            begin
                sq1_reg[i] <= mul_q(ext_m(e1_reg[i]), ext_m(e1_reg[i]));
                sq2_reg[i] <= mul_q(ext_m(e2_reg[i]), ext_m(e2_reg[i]));
                sq4_reg[i] <= mul_q(ext_m(e4_reg[i]), ext_m(e4_reg[i]));
            end
            t1_7_reg  <= t1_6_reg;
            diff7_reg <= diff6_reg;
            feas7_reg <= feas6_reg;

            w3_reg <= mul_q(ext_m(r2_reg), ext_m(sq3_reg));
            for (int i = 0; i < 3; i++)
            begin
                w4_reg[i]   <= mul_q(ext_m(r2_reg), ext_m(sq4_reg[i]));
                sq1b_reg[i] <= sq1_reg[i];
                sq2b_reg[i] <= sq2_reg[i];
            end
            t1_8_reg  <= t1_7_reg;
            diff8_reg <= diff7_reg;
            feas8_reg <= feas7_reg;

            for (int i = 0; i < 3; i++)
                obj_reg[i] <= ext_m(sq1b_reg[i]) + ext_m(sq2b_reg[i])
                            + ext_m(w3_reg) + ext_m(w4_reg[i]);
            t1_9_reg  <= t1_8_reg;
            diff9_reg <= diff8_reg;
            feas9_reg <= feas8_reg;

            s10_reg <= s10_next;

            side2_reg[0] <= s10_reg;
            for (int k = 1; k < DIV_LAT; k++)
                side2_reg[k] <= side2_reg[k-1];

            out_t1_reg   <= side2_reg[DIV_LAT-1].t1;
            out_t2_reg   <= side2_reg[DIV_LAT-1].t2;
            out_kind_reg <= side2_reg[DIV_LAT-1].kind;
            out_pa_reg   <= (reactance_reg == '0) ? '0 : q_pa;
            out_pb_reg   <= (reactance_reg == '0) ? '0 : q_pb;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_pb_reg, out_pa_reg, out_t2_reg, out_t1_reg};
    assign m_tuser  = out_kind_reg;

endmodule

// File: src/lfap_div.sv
// Pipelined signed fixed-point divider, one quotient bit per stage, saturated result.
module lfap_div (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                en,
    input  logic                                in_valid,
    input  logic signed [lfap_pkg::NUM_W-1:0]   num,
    input  logic        [lfap_pkg::DEN_W-1:0]   den,
    output logic                                out_valid,
    output logic signed [lfap_pkg::Q_W-1:0]     quo
);
    import lfap_pkg::*;

    localparam int WIDE_W = NUM_W + FRAC_BITS;
    localparam int HI_W   = WIDE_W - 32;

    div_stage_t           st_reg [DIV_STEPS+1];
    logic [DIV_STEPS+1:0] valid_reg;
    logic signed [Q_W-1:0] quo_reg;

    div_stage_t           prep_next;
    logic [NUM_W-1:0]     mag;
    logic [WIDE_W-1:0]    wide;
    logic [DEN_W-1:0]     hi;
    logic [31:0]          q;
    logic signed [Q_W-1:0] quo_next;

    function automatic div_stage_t step(input div_stage_t s);
        div_stage_t     o;
        logic [DEN_W:0] t;
        o = s;
        t = {s.rem, s.work[31]};
        if (t >= {1'b0, s.den})
        begin
            o.rem  = DEN_W'(t - {1'b0, s.den});
            o.work = {s.work[30:0], 1'b1};
        end
        else
        begin
            o.rem  = t[DEN_W-1:0];
            o.work = {s.work[30:0], 1'b0};
        end
        return o;
    endfunction

    // Quotients of 2^32 or more saturate; the high part seeds the remainder.
    always_comb
    begin
        mag  = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
        wide = {mag, {FRAC_BITS{1'b0}}};
        hi   = {{(DEN_W-HI_W){1'b0}}, wide[WIDE_W-1:32]};
        prep_next.neg  = num[NUM_W-1];
        prep_next.ovf  = (hi >= den);
        prep_next.rem  = prep_next.ovf ? '0 : hi;
        prep_next.work = wide[31:0];
        prep_next.den  = den;
    end

    always_comb
    begin
        q = st_reg[DIV_STEPS].work;
        if (st_reg[DIV_STEPS].neg)
        begin
            if (st_reg[DIV_STEPS].ovf || (q > 32'h8000_0000))
                quo_next = {1'b1, {(Q_W-1){1'b0}}};
            else
                quo_next = Q_W'(-q);
        end
        else
        begin
            if (st_reg[DIV_STEPS].ovf || (q > 32'h7FFF_FFFF))
                quo_next = {1'b0, {(Q_W-1){1'b1}}};
            else
                quo_next = q;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (en)
            valid_reg <= {valid_reg[DIV_STEPS:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            st_reg[0] <= prep_next;
            for (int k = 1; k <= DIV_STEPS; k++)
                st_reg[k] <= step(st_reg[k-1]);
            quo_reg <= quo_next;
        end
    end

    assign out_valid = valid_reg[DIV_STEPS+1];
    assign quo       = quo_reg;

endmodule

// File: src/lfap_checker.sv
// Port-level checker for the line flow proximal step, bound to the top level.
`include "assert_macros.svh"

module lfap_checker (
    input logic         clk,
    input logic         rst_n,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [127:0] m_tdata,
    input logic [1:0]   m_tuser
);
    import lfap_pkg::*;

    `ASSERT_NEXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid)
    `ASSERT_NEXT(a_out_stable, clk, rst_n, m_tvalid && !m_tready, $stable({m_tuser, m_tdata}))
    `ASSERT_IMPLIES(a_stall_back, clk, rst_n, m_tvalid && !m_tready, !s_tready)
    `ASSERT_IMPLIES(a_case_code, clk, rst_n, m_tvalid, m_tuser <= LIMIT_LOWER)

endmodule

bind line_flow_admm_proximal_step lfap_checker u_lfap_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

// File: verif/line_flow_admm_proximal_step_checker.sv
// Checker: watches config writes and both streams, predicts each line update and compares.
`timescale 1ns / 1ps

module line_flow_admm_proximal_step_checker (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [383:0] s_tdata,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [127:0] m_tdata,
    input  logic [1:0]   m_tuser,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [lfap_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]  pwdata,
    input  logic         pready,
    output int           errors,
    output int           pending
);
    import lfap_pkg::*;

    typedef struct {
        logic signed [31:0] angle_a;
        logic signed [31:0] angle_b;
        logic signed [31:0] power_a;
        logic signed [31:0] power_b;
        limit_case_t        lcase;
    } line_update_t;

    localparam longint Q1    = longint'(1) << FRAC_BITS;
    localparam longint QMAX  = 64'sd2147483647;
    localparam longint QMIN  = -64'sd2147483648;

    logic [30:0] reactance;
    logic [30:0] flow_limit;
    logic [1:0]  slack_end;

    line_update_t updates_due[$];

    assign pending = updates_due.size();

    function automatic longint clamp_q(longint v);
        if (v > QMAX) return QMAX;
        if (v < QMIN) return QMIN;
        return v;
    endfunction

    function automatic longint qmul(longint a, longint b);
        longint p;
        p = a * b;
        return clamp_q(p >>> FRAC_BITS);
    endfunction

    // Truncates toward zero, as the hardware divider does.
    function automatic longint qdiv(longint n, longint m);
        return clamp_q((n * Q1) / m);
    endfunction

    function automatic longint cost_at(longint x, longint a, longint b, longint c,
                                       longint d, longint t1, longint r2);
        longint e1, e2, e3, e4;
        e1 = clamp_q(x - a);
        e2 = clamp_q(x + c);
        e3 = clamp_q(t1 - b);
        e4 = clamp_q(t1 + x - d);
        return qmul(e1, e1) + qmul(e2, e2) + qmul(r2, qmul(e3, e3))
               + qmul(r2, qmul(e4, e4));
    endfunction

    function automatic longint fld(logic [383:0] v, int k);
        return longint'($signed(v[32*k +: 32]));
    endfunction

    function automatic line_update_t solve_line(logic [383:0] v);
        line_update_t u;
        longint r, a, b, c, d, r2, t1, t2, diff, lim, pick, o1, o2, o3;
        limit_case_t k;
        r  = longint'(reactance);
        a  = qmul(r, clamp_q(fld(v, 0) - fld(v, 1) - fld(v, 2)));
        b  = clamp_q(fld(v, 3) + fld(v, 4) - fld(v, 5));
        c  = qmul(r, clamp_q(fld(v, 6) - fld(v, 7) - fld(v, 8)));
        d  = clamp_q(fld(v, 9) + fld(v, 10) - fld(v, 11));
        r2 = qmul(r, r);
        if (slack_end == SLACK_END_A)
        begin
            t1   = 0;
            diff = qdiv(qmul(r2, d) + a - c, 2 * Q1 + r2);
        end
        else if (slack_end == SLACK_END_B)
        begin
            t1   = qdiv(qmul(r2, b) - a + c, 2 * Q1 + r2);
            diff = clamp_q(-t1);
        end
        else
        begin
            t1   = qdiv(qmul(2 * Q1 + r2, b) - a + c + 2 * d, 4 * Q1 + r2);
            diff = qdiv(2 * a - qmul(r2, b) - 2 * c + qmul(r2, d), 4 * Q1 + r2);
        end
        lim = qmul(r, longint'(flow_limit));
        o1  = cost_at(lim, a, b, c, d, t1, r2);
        o2  = cost_at(-lim, a, b, c, d, t1, r2);
        if (diff <= lim && diff >= -lim)
        begin
            o3 = cost_at(diff, a, b, c, d, t1, r2);
            if (o1 <= o2 && o1 <= o3)
                k = LIMIT_UPPER;
            else if (o2 <= o3)
                k = LIMIT_LOWER;
            else
                k = LIMIT_INTERIOR;
        end
        else
            k = (o1 <= o2) ? LIMIT_UPPER : LIMIT_LOWER;
        pick = (k == LIMIT_UPPER) ? lim : (k == LIMIT_LOWER) ? -lim : diff;
        if (slack_end == SLACK_END_B)
        begin
            t2 = 0;
            t1 = clamp_q(-pick);
        end
        else
            t2 = clamp_q(t1 + pick);
        u.angle_a = t1[31:0];
        u.angle_b = t2[31:0];
        u.power_a = (r > 0) ? 32'(qdiv(t2 - t1, r)) : '0;
        u.power_b = (r > 0) ? 32'(qdiv(t1 - t2, r)) : '0;
        u.lcase   = k;
        return u;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        line_update_t want;
        if (!rst_n)
        begin
            reactance  <= 31'h10000;
            flow_limit <= 31'h10000;
            slack_end  <= SLACK_NONE;
            errors     = 0;
            updates_due.delete();
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[3:2])
                    REG_REACTANCE:  reactance  <= pwdata[30:0];
                    REG_FLOW_LIMIT: flow_limit <= pwdata[30:0];
                    REG_SLACK_END:  slack_end  <= pwdata[1:0];
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready)
            begin
                if (updates_due.size() == 0)
                begin
                    $display("unexpected result transaction at %0t", $realtime);
                    errors++;
                end
                else
                begin
                    want = updates_due.pop_front();
                    if ($signed(m_tdata[31:0]) != want.angle_a)
                        report_mismatch("angle_out_a", $signed(m_tdata[31:0]), want.angle_a);
                    if ($signed(m_tdata[63:32]) != want.angle_b)
                        report_mismatch("angle_out_b", $signed(m_tdata[63:32]), want.angle_b);
                    if ($signed(m_tdata[95:64]) != want.power_a)
                        report_mismatch("power_out_a", $signed(m_tdata[95:64]), want.power_a);
                    if ($signed(m_tdata[127:96]) != want.power_b)
                        report_mismatch("power_out_b", $signed(m_tdata[127:96]), want.power_b);
                    if (m_tuser != want.lcase)
                        report_mismatch("limit_case", m_tuser, want.lcase);
                end
            end
            if (s_tvalid && s_tready)
                updates_due.push_back(solve_line(s_tdata));
        end
    end

endmodule

// File: verif/line_flow_admm_proximal_step_tb.sv
// Testbench top: clock, reset, line stimulus, config phases and verdict.
`timescale 1ns / 1ps

module line_flow_admm_proximal_step_tb;
    import lfap_pkg::*;

    localparam logic [1:0] REG_SPARE = 2'd3;
    localparam int IDLE_LIMIT = 3000;

    logic                clk;
    logic                rst_n;
    logic                s_tvalid;
    logic                s_tready;
    logic [383:0]        s_tdata;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [127:0]        m_tdata;
    logic [1:0]          m_tuser;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [ADDR_W-1:0]   paddr;
    logic [31:0]         pwdata;
    logic [31:0]         prdata;
    logic                pready;
    int                  errors;
    int                  pending;
    int                  gap_pct;
    int                  stall_pct;
    int                  idle_cycles = 0;

    line_flow_admm_proximal_step dut (.*);

    line_flow_admm_proximal_step_checker checker_i (.*);

    initial clk = 1'b0;
    always #4 clk = ~clk;

    always @(posedge clk)
        m_tready <= !(stall_pct > 0 && $urandom_range(99) < stall_pct);

    // End the run when no transaction of any kind moves for too long.
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    task automatic write_reg(logic [1:0] idx, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [31:0] rand_q();
        case ($urandom_range(7))
            0, 1:    return $urandom();
            2:       return $urandom_range(3) == 0 ? 32'h7fffffff : 32'h80000000;
            3:       return 32'($signed($urandom_range(1 << 25)) - (1 << 24));
            default: return 32'($signed($urandom_range(1 << 19)) - (1 << 18));
        endcase
    endfunction

    task automatic send_line(logic [383:0] v);
        if (gap_pct > 0)
        begin
            while ($urandom_range(99) < gap_pct)
            begin
                s_tvalid <= 1'b0;
                @(posedge clk);
            end
        end
        s_tvalid <= 1'b1;
        s_tdata  <= v;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    task automatic send_random(int n);
        logic [383:0] v;
        repeat (n)
        begin
            for (int k = 0; k < 12; k++)
                v[32*k +: 32] = rand_q();
            send_line(v);
        end
        s_tvalid <= 1'b0;
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
    endtask

    task automatic set_phase(logic [31:0] r, logic [31:0] lim, logic [1:0] slack,
                             int gap, int stall);
        drain();
        write_reg(REG_REACTANCE, r);
        write_reg(REG_FLOW_LIMIT, lim);
        write_reg(REG_SLACK_END, {30'd0, slack});
        gap_pct   = gap;
        stall_pct = stall;
    endtask

    initial
    begin
        logic [383:0] v;
        rst_n       = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        gap_pct     = 0;
        stall_pct   = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: field extremes, then mixed patterns.
        send_line('0);
        send_line({12{32'h7fffffff}});
        send_line({12{32'h80000000}});
        send_line({6{32'h80000000, 32'h7fffffff}});
        send_line({6{32'h7fffffff, 32'h80000000}});
        send_line({{6{32'h80000000}}, {6{32'h7fffffff}}});
        send_line({{6{32'h7fffffff}}, {6{32'h80000000}}});
        send_line({12{32'hffffffff}});
        send_line({12{32'h00000001}});
        for (int k = 0; k < 12; k++)
        begin
            v = '0;
            v[32*k +: 32] = (k % 2) ? 32'h80000000 : 32'h7fffffff;
            send_line(v);
        end
        send_random(55);

        set_phase(32'h7fffffff, 32'h7fffffff, SLACK_END_A, 49, 0);
        send_random(65);
        set_phase(32'h1, 32'h0, SLACK_END_B, 0, 49);
        send_random(65);
        set_phase(32'h8000, 32'h20000, SLACK_NONE, 24, 24);
        send_random(65);
        // Zero reactance, slack code three, and a write past the last register.
        set_phase(32'h0, 32'h10000, 2'd3, 0, 0);
        write_reg(REG_SPARE, $urandom());
        send_random(65);
        set_phase(32'h18000, 32'h8000, SLACK_END_A, 24, 24);
        send_random(65);
        set_phase($urandom_range(32'h40000, 1), $urandom_range(32'h40000),
                  SLACK_END_B, 49, 0);
        send_random(65);
        set_phase(32'h10000, 32'h40000, SLACK_NONE, 0, 49);
        send_random(65);
        set_phase($urandom(), $urandom(), 2'($urandom_range(3)), 24, 24);
        send_random(65);
        set_phase($urandom_range(32'h30000, 1), $urandom_range(32'h30000),
                  SLACK_NONE, 0, 0);
        send_random(65);

        drain();
        if (errors == 0 && pending == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// File: filelist.f
+incdir+src
src/lfap_pkg.sv
src/lfap_div.sv
src/line_flow_admm_proximal_step.sv
src/lfap_checker.sv
verif/line_flow_admm_proximal_step_checker.sv
verif/line_flow_admm_proximal_step_tb.sv
